FILE: src/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg
// Shared constants, codes and types of the Otsu threshold binariser.
// ----------------------------------------------------------------------------
package otb_pkg;

  localparam int unsigned LEVELS_DEF     = 256;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // command codes
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_COMPUTE  = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;

  // result kinds
  localparam logic KIND_THRESHOLD = 1'b0;
  localparam logic KIND_PIXEL     = 1'b1;

  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;

  // histogram status towards the control logic
  typedef struct packed {
    logic clr_busy;     // clearing pass after reset in progress
    logic add_pending;  // bin increment still to be written back
  } otb_hist_stat_t;

endpackage

FILE: src/otb_if.sv
// ----------------------------------------------------------------------------
// otb_in_if / otb_out_if
// Valid/ready channels for pixel commands and for results.
// ----------------------------------------------------------------------------
interface otb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] pixel;

  modport source (output valid, output command, output pixel, input ready);
  modport sink   (input valid, input command, input pixel, output ready);
endinterface

interface otb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       out_kind;

  modport source (output valid, output out_value, output out_kind, input ready);
  modport sink   (input valid, input out_value, input out_kind, output ready);
endinterface

FILE: src/otb_hist.sv
// ----------------------------------------------------------------------------
// otb_hist
// Histogram memory: increment per added pixel, read-and-clear for the scan,
// clearing pass after reset.
// ----------------------------------------------------------------------------
module otb_hist
  import otb_pkg::*;
#(
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  localparam int unsigned LB        = $clog2(LEVELS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  add_i,
  input  logic [LB-1:0]         add_level_i,
  input  logic                  rd_i,
  input  logic [LB-1:0]         rd_addr_i,
  output logic [COUNT_BITS-1:0] rd_data_o,
  output otb_hist_stat_t        stat_o
);

  logic [COUNT_BITS-1:0] mem [LEVELS];
  logic [COUNT_BITS-1:0] rdata_q;

  logic                  clr_q, clr_d;
  logic [LB-1:0]         clr_addr_q, clr_addr_d;
  logic                  s2_v_q;
  logic [LB-1:0]         s2_lvl_q;
  logic                  lw_v_q;
  logic [LB-1:0]         lw_addr_q;
  logic [COUNT_BITS-1:0] lw_data_q;

  logic                  wr_en;
  logic [LB-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] cur;
  logic [LB-1:0]         raddr;

  // back-to-back adds to one bin: take the value just written
  assign cur = (lw_v_q && lw_addr_q == s2_lvl_q) ? lw_data_q : rdata_q;
  assign raddr = rd_i ? rd_addr_i : add_level_i;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_lvl_q;
    wr_data = cur + COUNT_BITS'(1);
    priority if (clr_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else if (rd_i) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_i;
      wr_data = '0;
    end else if (s2_v_q) begin
      wr_en   = 1'b1;
    end
  end

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == LB'(LEVELS - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + LB'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s2_v_q     <= 1'b0;
      lw_v_q     <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      s2_v_q     <= add_i;
      lw_v_q     <= s2_v_q && !clr_q && !rd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_lvl_q  <= add_level_i;
    lw_addr_q <= s2_lvl_q;
    lw_data_q <= wr_data;
  end

  assign rd_data_o          = rdata_q;
  assign stat_o.clr_busy    = clr_q;
  assign stat_o.add_pending = s2_v_q;

endmodule

FILE: src/otb_mul.sv
// ----------------------------------------------------------------------------
// otb_mul
// Shift-and-add multiplier, one multiplier bit per cycle, early finish.
// ----------------------------------------------------------------------------
module otb_mul
  import otb_pkg::*;
#(
  parameter int unsigned LW = 160,
  parameter int unsigned MB = 56
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [LW-1:0] a_i,
  input  logic [MB-1:0] b_i,
  output logic          done_o,
  output logic [LW-1:0] p_o
);

  logic          busy_q;
  logic [LW-1:0] a_q;
  logic [MB-1:0] b_q;
  logic [LW-1:0] acc_q;

  assign done_o = busy_q && (b_q == '0);
  assign p_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && b_q != '0) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule

FILE: src/otb_scan.sv
// ----------------------------------------------------------------------------
// otb_scan
// Threshold sequencer: walks the bins, rates each split by exact integer
// between-class variance and keeps the first strict maximum.
// ----------------------------------------------------------------------------
module otb_scan
  import otb_pkg::*;
#(
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  localparam int unsigned LB        = $clog2(LEVELS),
  localparam int unsigned CB        = COUNT_BITS,
  localparam int unsigned SB        = CB + LB,
  localparam int unsigned P         = SB + CB,
  localparam int unsigned LW        = 2 * P + 2 * CB
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [CB-1:0] total_i,
  input  logic [SB-1:0] sum_i,
  output logic          rd_o,
  output logic [LB-1:0] rd_addr_o,
  input  logic [CB-1:0] rd_data_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [LB-1:0] thr_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD     = 3'd1;
  localparam logic [2:0] ST_ACC    = 3'd2;
  localparam logic [2:0] ST_CHK    = 3'd3;
  localparam logic [2:0] ST_LAUNCH = 3'd4;
  localparam logic [2:0] ST_MUL    = 3'd5;
  localparam logic [2:0] ST_CMP    = 3'd6;
  localparam logic [2:0] ST_NEXT   = 3'd7;

  localparam logic [2:0] OP_P1  = 3'd0;  // S1 * W
  localparam logic [2:0] OP_P2  = 3'd1;  // S * w1
  localparam logic [2:0] OP_NUM = 3'd2;  // d * d
  localparam logic [2:0] OP_DEN = 3'd3;  // w1 * w2
  localparam logic [2:0] OP_LHS = 3'd4;  // num * best_den
  localparam logic [2:0] OP_RHS = 3'd5;  // best_num * den

  logic [2:0]      state_q, state_d;
  logic [2:0]      op_q, op_d;
  logic [LB-1:0]   t_q, t_d;
  logic [CB-1:0]   w1_q, w1_d;
  logic [SB-1:0]   s1_q, s1_d;
  logic [P-1:0]    p1_q, p1_d, p2_q, p2_d;
  logic [2*P-1:0]  num_q, num_d, bnum_q, bnum_d;
  logic [2*CB-1:0] den_q, den_d, bden_q, bden_d;
  logic [LW-1:0]   lhs_q, lhs_d;
  logic [LB-1:0]   best_q, best_d;

  logic [CB-1:0]   w2;
  logic [P-1:0]    dif;
  logic            mul_start, mul_done;
  logic [LW-1:0]   mul_a, mul_p;
  logic [P-1:0]    mul_b;

  assign w2  = total_i - w1_q;
  assign dif = (p1_q >= p2_q) ? (p1_q - p2_q) : (p2_q - p1_q);

  always_comb begin
    unique case (op_q)
      OP_P1:   begin mul_a = LW'(s1_q);   mul_b = P'(total_i); end
      OP_P2:   begin mul_a = LW'(sum_i);  mul_b = P'(w1_q);    end
      OP_NUM:  begin mul_a = LW'(dif);    mul_b = dif;         end
      OP_DEN:  begin mul_a = LW'(w1_q);   mul_b = P'(w2);      end
      OP_LHS:  begin mul_a = LW'(num_q);  mul_b = P'(bden_q);  end
      OP_RHS:  begin mul_a = LW'(bnum_q); mul_b = P'(den_q);   end
      default: begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  assign mul_start = (state_q == ST_LAUNCH);

  otb_mul #(.LW(LW), .MB(P)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    t_d     = t_q;
    w1_d    = w1_q;
    s1_d    = s1_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    num_d   = num_q;
    den_d   = den_q;
    lhs_d   = lhs_q;
    bnum_d  = bnum_q;
    bden_d  = bden_q;
    best_d  = best_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          t_d     = '0;
          w1_d    = '0;
          s1_d    = '0;
          bnum_d  = '0;
          bden_d  = (2*CB)'(1);
          best_d  = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_ACC;
      ST_ACC: begin
        w1_d    = w1_q + rd_data_i;
        s1_d    = s1_q + SB'(t_q) * SB'(rd_data_i);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        // an empty class rates zero and never wins
        if (w1_q == '0 || w2 == '0) begin
          state_d = ST_NEXT;
        end else begin
          op_d    = OP_P1;
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_d = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          unique case (op_q)
            OP_P1:   p1_d  = P'(mul_p);
            OP_P2:   p2_d  = P'(mul_p);
            OP_NUM:  num_d = (2*P)'(mul_p);
            OP_DEN:  den_d = (2*CB)'(mul_p);
            OP_LHS:  lhs_d = mul_p;
            default: ;
          endcase
          if (op_q == OP_RHS) begin
            state_d = ST_CMP;
          end else begin
            op_d    = op_q + 3'd1;
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_CMP: begin
        if (lhs_q > mul_p) begin
          bnum_d = num_q;
          bden_d = den_q;
          best_d = t_q;
        end
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (t_q == LB'(LEVELS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          t_d     = t_q + LB'(1);
          state_d = ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_P1;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      t_q     <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q   <= w1_d;
    s1_q   <= s1_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    num_q  <= num_d;
    den_q  <= den_d;
    lhs_q  <= lhs_d;
    bnum_q <= bnum_d;
    bden_q <= bden_d;
    best_q <= best_d;
  end

  assign rd_o      = (state_q == ST_RD);
  assign rd_addr_o = t_q;
  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = (state_q == ST_NEXT) && (t_q == LB'(LEVELS - 1));
  assign thr_o     = best_d;

endmodule

FILE: src/otsu_threshold_binarizer_core.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_core
// Otsu threshold binariser: histogram build, threshold search, classify.
// ----------------------------------------------------------------------------
// Channels: in_i carries one command per transaction (add pixel to the
// histogram, compute threshold, classify pixel); out_o carries one result per
// compute or classify transaction, add gives none.
// Add and classify may follow each other every cycle unless out_o stalls;
// the bin increment is a read-modify-write of the histogram memory with
// forwarding between back-to-back adds to the same bin. A classify result is
// on out_o the cycle after its transaction.
// Compute holds in_i off while the sequencer walks all LEVELS bins; each
// non-empty split costs six shift-and-add multiplies on the shared unit (one
// multiplier bit per cycle, early finish) and an empty split skips them.
// Bins are cleared as they are read. After reset the histogram memory is
// swept to zero with in_i not ready. When out_o stalls, one result waits in
// the output register and in_i takes no further transaction, whatever its
// command, until the waiting one leaves (a transaction may be taken in the
// cycle it leaves).
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer_core
  import otb_pkg::*;
#(
  parameter int unsigned LEVELS     = LEVELS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  otb_in_if.sink            in_i,
  otb_out_if.source         out_o
);

  localparam int unsigned LB = $clog2(LEVELS);
  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned SB = CB + LB;

  otb_hist_stat_t  hstat;
  logic [CB-1:0]   hist_rd_data;
  logic            scan_rd, scan_busy, scan_done;
  logic [LB-1:0]   scan_rd_addr, scan_thr;

  logic [CB-1:0]   total_q, total_d;
  logic [SB-1:0]   sum_q, sum_d;
  logic [LB-1:0]   chosen_q, chosen_d;
  logic            out_v_q, out_v_d;
  logic [7:0]      out_val_q, out_val_d;
  logic            out_kind_q, out_kind_d;

  logic            in_acc, is_add, add_go;
  logic [LB-1:0]   level;
  logic [31:0]     thr32;

  // ready does not depend on the command being offered
  assign in_i.ready = !hstat.clr_busy && !scan_busy && (!out_v_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_add     = in_acc && (in_i.command == CMD_ADD);
  // saturated totals: further adds are dropped altogether
  assign add_go     = is_add && (total_q != '1);

  // pixels past the top bin land in the top bin
  always_comb begin
    if (32'(in_i.pixel) > 32'(LEVELS - 1)) begin
      level = LB'(LEVELS - 1);
    end else begin
      level = LB'(in_i.pixel);
    end
  end

  otb_hist #(.LEVELS(LEVELS), .COUNT_BITS(CB)) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .add_i       (add_go),
    .add_level_i (level),
    .rd_i        (scan_rd),
    .rd_addr_i   (scan_rd_addr),
    .rd_data_o   (hist_rd_data),
    .stat_o      (hstat)
  );

  otb_scan #(.LEVELS(LEVELS), .COUNT_BITS(CB)) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc && in_i.command == CMD_COMPUTE),
    .total_i   (total_q),
    .sum_i     (sum_q),
    .rd_o      (scan_rd),
    .rd_addr_o (scan_rd_addr),
    .rd_data_i (hist_rd_data),
    .busy_o    (scan_busy),
    .done_o    (scan_done),
    .thr_o     (scan_thr)
  );

  assign thr32 = 32'(scan_thr);

  always_comb begin
    total_d    = total_q;
    sum_d      = sum_q;
    chosen_d   = chosen_q;
    out_v_d    = out_v_q && !out_o.ready;
    out_val_d  = out_val_q;
    out_kind_d = out_kind_q;
    if (add_go) begin
      total_d = total_q + CB'(1);
      sum_d   = sum_q + SB'(level);
    end
    if (in_acc && in_i.command == CMD_CLASSIFY) begin
      out_v_d    = 1'b1;
      out_kind_d = KIND_PIXEL;
      out_val_d  = (32'(in_i.pixel) > 32'(chosen_q)) ? PIX_WHITE : PIX_BLACK;
    end
    if (scan_done) begin
      // histogram bins were cleared during the walk; totals follow here
      total_d    = '0;
      sum_d      = '0;
      chosen_d   = scan_thr;
      out_v_d    = 1'b1;
      out_kind_d = KIND_THRESHOLD;
      out_val_d  = thr32[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      sum_q    <= '0;
      chosen_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      total_q  <= total_d;
      sum_q    <= sum_d;
      chosen_q <= chosen_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q  <= out_val_d;
    out_kind_q <= out_kind_d;
  end

  assign out_o.valid     = out_v_q;
  assign out_o.out_value = out_val_q;
  assign out_o.out_kind  = out_kind_q;

  // the sequencer's bin reads must never meet an increment still in flight
  a_no_add_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_busy |-> !hstat.add_pending)
    else $error("bin increment pending during threshold scan");

  // a finished scan always finds the output register free
  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> !out_v_q)
    else $error("threshold result would overwrite a waiting result");

  // binarised pixels are black or white only
  a_pixel_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_kind_q == KIND_PIXEL) |->
      (out_val_q == PIX_WHITE || out_val_q == PIX_BLACK))
    else $error("classify result neither black nor white");

endmodule
